/* hw/rtl/echo_range_to_segments_unit_macros.svh */
// Assertion macros used by the checker of the echo range unit.
// Each macro expects a signal named clk, and all but ERTS_ASSERT_RST also rst_n, in the scope where it is used.
`ifndef ECHO_RANGE_TO_SEGMENTS_UNIT_MACROS_SVH
`define ECHO_RANGE_TO_SEGMENTS_UNIT_MACROS_SVH

// Implication checked at every edge outside reset.
`define ERTS_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Implication whose consequent is checked at the next edge, outside reset.
`define ERTS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Next-edge implication that is also checked while reset is asserted.
`define ERTS_ASSERT_RST(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

/* hw/rtl/erts_pkg.sv */
// Package of the echo range unit: widths, constants, types and the segment encoder.
// No dependencies; the other files of the unit but erts_in_if and the macro header use it by scoped names.
package erts_pkg;

  localparam int COUNT_BITS  = 8;
  localparam int SCALE_BITS  = 12;
  localparam int RANGE_BITS  = 11;
  localparam int SEG_BITS    = 7;
  localparam int DIGIT_BITS  = 4;

  localparam logic [SCALE_BITS-1:0] SCALE_RESET = 12'd1098;
  localparam logic [RANGE_BITS-1:0] RANGE_MAX   = 11'd2047;

  // Product of tick difference and scale, and its division by 1000.
  localparam int          PROD_BITS  = COUNT_BITS + SCALE_BITS;
  localparam int          DIV_K      = 1000;
  localparam int unsigned RECIP      = (32'd1 << PROD_BITS) / DIV_K;
  localparam int          RECIP_BITS = $clog2(RECIP + 1);
  localparam int          MUL_BITS   = PROD_BITS + RECIP_BITS;
  localparam int          Q_BITS     = PROD_BITS - 9;

  // Job queue between front and back.
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
  localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    PH_IDLE      = 2'd0,
    PH_WAIT_HIGH = 2'd1,
    PH_WAIT_LOW  = 2'd2
  } phase_t;

  // One finished measurement: tick difference and whether fall was above rise.
  typedef struct packed {
    logic                  upd;
    logic [COUNT_BITS-1:0] diff;
  } job_t;

  // Segment code, bits g..a, of one decimal digit.
  function automatic logic [SEG_BITS-1:0] seg_of(input logic [DIGIT_BITS-1:0] d);
    logic [SEG_BITS-1:0] s;
    case (d)
      4'd0: s = 7'h3F;
      4'd1: s = 7'h06;
      4'd2: s = 7'h5B;
      4'd3: s = 7'h4F;
      4'd4: s = 7'h66;
      4'd5: s = 7'h6D;
      4'd6: s = 7'h7D;
      4'd7: s = 7'h07;
      4'd8: s = 7'h7F;
      4'd9: s = 7'h67;
      default: s = 7'h3F;
    endcase
    return s;
  endfunction

endpackage

/* hw/rtl/erts_in_if.sv */
// Input channel of the echo range unit: one timer tick per beat.
// Depends on nothing but the handshake; fields are single bits.
interface erts_in_if;
  logic valid;
  logic ready;
  logic start_req;
  logic echo;

  modport source(output valid, start_req, echo, input ready);
  modport sink(input valid, start_req, echo, output ready);
endinterface

/* hw/rtl/erts_out_if.sv */
// Result channel of the echo range unit: one measurement result per beat.
// Depends on erts_pkg for field widths.
interface erts_out_if;
  logic                          valid;
  logic                          ready;
  logic [erts_pkg::RANGE_BITS-1:0] range_cm;
  logic                          updated;
  logic [erts_pkg::SEG_BITS-1:0]   seg_thousands;
  logic [erts_pkg::SEG_BITS-1:0]   seg_hundreds;
  logic [erts_pkg::SEG_BITS-1:0]   seg_tens;
  logic [erts_pkg::SEG_BITS-1:0]   seg_ones;

  modport source(output valid, range_cm, updated, seg_thousands, seg_hundreds,
                 seg_tens, seg_ones, input ready);
  modport sink(input valid, range_cm, updated, seg_thousands, seg_hundreds,
               seg_tens, seg_ones, output ready);
endinterface

/* hw/rtl/erts_front.sv */
// Front of the echo range unit: tick counter and measurement phase machine.
// Depends on erts_pkg and erts_in_if; emits one job per finished measurement.
module erts_front (
  input  logic              clk,
  input  logic              rst_n,
  erts_in_if.sink           in_ch,
  input  logic              q_full,
  output logic              push,
  output erts_pkg::job_t    job
);

  erts_pkg::phase_t                phase_r, phase_nxt;
  logic [erts_pkg::COUNT_BITS-1:0] tick_r, tick_nxt;
  logic [erts_pkg::COUNT_BITS-1:0] rise_r, rise_nxt;
  logic [erts_pkg::COUNT_BITS-1:0] tick_inc;
  logic                            accept;

  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && in_ch.ready;
  assign tick_inc    = tick_r + erts_pkg::COUNT_BITS'(1);

  // Next phase.
  always_comb begin
    phase_nxt = phase_r;
    if (accept) begin
      if (in_ch.start_req) begin
        phase_nxt = erts_pkg::PH_WAIT_HIGH;
      end else begin
        case (phase_r)
          erts_pkg::PH_WAIT_HIGH: begin
            if (in_ch.echo) phase_nxt = erts_pkg::PH_WAIT_LOW;
          end
          erts_pkg::PH_WAIT_LOW: begin
            if (!in_ch.echo) phase_nxt = erts_pkg::PH_IDLE;
          end
          default: phase_nxt = phase_r;
        endcase
      end
    end
  end

  // Counter, rise capture and job output.
  always_comb begin
    tick_nxt = tick_r;
    rise_nxt = rise_r;
    push     = 1'b0;
    job.upd  = tick_inc > rise_r;
    job.diff = tick_inc - rise_r;
    if (accept) begin
      if (in_ch.start_req) begin
        tick_nxt = '0;
      end else begin
        tick_nxt = tick_inc;
        case (phase_r)
          erts_pkg::PH_WAIT_HIGH: begin
            if (in_ch.echo) rise_nxt = tick_inc;
          end
          erts_pkg::PH_WAIT_LOW: begin
            push = !in_ch.echo;
          end
          default: push = 1'b0;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= erts_pkg::PH_IDLE;
      tick_r  <= '0;
      rise_r  <= '0;
    end else begin
      phase_r <= phase_nxt;
      tick_r  <= tick_nxt;
      rise_r  <= rise_nxt;
    end
  end

endmodule

/* hw/rtl/erts_queue.sv */
// Short job queue between the front and back of the echo range unit.
// Depends on erts_pkg; push and pop may happen in the same cycle.
module erts_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  erts_pkg::job_t push_job,
  input  logic           pop,
  output erts_pkg::job_t head,
  output logic           avail,
  output logic           full
);

  erts_pkg::job_t                 slot_r [erts_pkg::QUEUE_DEPTH];
  logic [erts_pkg::QPTR_BITS-1:0] wr_r, rd_r;
  logic [erts_pkg::QCNT_BITS-1:0] cnt_r, cnt_nxt;

  assign head  = slot_r[rd_r];
  assign avail = cnt_r != '0;
  assign full  = cnt_r == erts_pkg::QCNT_BITS'(erts_pkg::QUEUE_DEPTH);

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) cnt_nxt = cnt_r + erts_pkg::QCNT_BITS'(1);
    if (pop && !push) cnt_nxt = cnt_r - erts_pkg::QCNT_BITS'(1);
  end

  always_ff @(posedge clk) begin
    if (push) slot_r[wr_r] <= push_job;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wr_r <= wr_r + erts_pkg::QPTR_BITS'(1);
      if (pop)  rd_r <= rd_r + erts_pkg::QPTR_BITS'(1);
      cnt_r <= cnt_nxt;
    end
  end

endmodule

/* hw/rtl/erts_back.sv */
// Back of the echo range unit: scaling, division by 1000, digit split, segments.
// Depends on erts_pkg and erts_out_if; an eight-stage pipeline that stalls as one.
module erts_back (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic [erts_pkg::SCALE_BITS-1:0] range_scale,
  input  erts_pkg::job_t                  head,
  input  logic                            avail,
  output logic                            pop,
  erts_out_if.source                      out_ch
);

  localparam int PB = erts_pkg::PROD_BITS;
  localparam int QB = erts_pkg::Q_BITS;
  localparam int RB = erts_pkg::RANGE_BITS;
  localparam int DB = erts_pkg::DIGIT_BITS;

  logic adv;
  logic v1_r, v2_r, v3_r, v4_r, v5_r, v6_r, v7_r, ov_r;

  // Stage payloads.
  logic [PB-1:0]  p1_r, p2_r;
  logic           upd1_r, upd2_r, upd3_r, upd4_r, upd5_r, upd6_r, upd7_r;
  logic [QB-1:0]  qe2_r;
  logic [RB-1:0]  held_r, range3_r, range4_r, range5_r, range6_r, range7_r;
  logic [1:0]     th4_r, th5_r, th6_r, th7_r;
  logic [9:0]     rem4_r, rem5_r;
  logic [DB-1:0]  h5_r, h6_r, h7_r, t7_r;
  logic [6:0]     rem6_r, rem7_r;

  logic [PB-1:0]                 p1_nxt;
  logic [erts_pkg::MUL_BITS-1:0] recip_prod;
  logic [QB-1:0]                 qe2_nxt;
  logic [PB-1:0]                 rem_div;
  logic [QB-1:0]                 q_fix;
  logic [RB-1:0]                 q_sat, range3_nxt;
  logic [1:0]                    th4_nxt;
  logic [9:0]                    rem4_nxt;
  logic [15:0]                   h_prod;
  logic [6:0]                    rem6_nxt;
  logic [14:0]                   t_prod;
  logic [DB-1:0]                 ones;

  assign adv = !ov_r || out_ch.ready;
  assign pop = adv && avail;

  // Scale the tick difference.
  assign p1_nxt = PB'(head.diff) * PB'(range_scale);

  // Quotient estimate by reciprocal; at most one below the true quotient.
  assign recip_prod = erts_pkg::MUL_BITS'(p1_r) *
                      erts_pkg::MUL_BITS'(erts_pkg::RECIP);
  assign qe2_nxt    = QB'(recip_prod >> PB);

  // Correct the estimate, saturate, and hold the previous range on no update.
  assign rem_div = p2_r - PB'(qe2_r) * PB'(erts_pkg::DIV_K);
  assign q_fix   = (rem_div >= PB'(erts_pkg::DIV_K)) ? qe2_r + QB'(1) : qe2_r;
  assign q_sat   = (32'(q_fix) > 32'(erts_pkg::RANGE_MAX)) ? erts_pkg::RANGE_MAX
                                                           : RB'(q_fix);
  assign range3_nxt = upd2_r ? q_sat : held_r;

  // Thousands digit by compare.
  always_comb begin
    if (range3_r >= RB'(2000)) begin
      th4_nxt  = 2'd2;
      rem4_nxt = 10'(range3_r - RB'(2000));
    end else if (range3_r >= RB'(1000)) begin
      th4_nxt  = 2'd1;
      rem4_nxt = 10'(range3_r - RB'(1000));
    end else begin
      th4_nxt  = 2'd0;
      rem4_nxt = 10'(range3_r);
    end
  end

  // Hundreds: x * 41 >> 12 equals x / 100 for x below 1000.
  assign h_prod   = 16'(rem4_r) * 16'd41;
  assign rem6_nxt = 7'(rem5_r - 10'(h5_r) * 10'd100);

  // Tens: x * 205 >> 11 equals x / 10 for x below 100.
  assign t_prod = 15'(rem6_r) * 15'd205;
  assign ones   = DB'(rem7_r - 7'(t7_r) * 7'd10);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r   <= 1'b0;
      v2_r   <= 1'b0;
      v3_r   <= 1'b0;
      v4_r   <= 1'b0;
      v5_r   <= 1'b0;
      v6_r   <= 1'b0;
      v7_r   <= 1'b0;
      ov_r   <= 1'b0;
      held_r <= '0;
    end else if (adv) begin
      v1_r <= avail;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
      v6_r <= v5_r;
      v7_r <= v6_r;
      ov_r <= v7_r;
      if (v2_r && upd2_r) held_r <= q_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p1_r     <= p1_nxt;
      upd1_r   <= head.upd;
      p2_r     <= p1_r;
      qe2_r    <= qe2_nxt;
      upd2_r   <= upd1_r;
      range3_r <= range3_nxt;
      upd3_r   <= upd2_r;
      range4_r <= range3_r;
      upd4_r   <= upd3_r;
      th4_r    <= th4_nxt;
      rem4_r   <= rem4_nxt;
      range5_r <= range4_r;
      upd5_r   <= upd4_r;
      th5_r    <= th4_r;
      rem5_r   <= rem4_r;
      h5_r     <= DB'(h_prod >> 12);
      range6_r <= range5_r;
      upd6_r   <= upd5_r;
      th6_r    <= th5_r;
      h6_r     <= h5_r;
      rem6_r   <= rem6_nxt;
      range7_r <= range6_r;
      upd7_r   <= upd6_r;
      th7_r    <= th6_r;
      h7_r     <= h6_r;
      rem7_r   <= rem6_r;
      t7_r     <= DB'(t_prod >> 11);
      out_ch.range_cm      <= range7_r;
      out_ch.updated       <= upd7_r;
      out_ch.seg_thousands <= erts_pkg::seg_of(DB'(th7_r));
      out_ch.seg_hundreds  <= erts_pkg::seg_of(h7_r);
      out_ch.seg_tens      <= erts_pkg::seg_of(t7_r);
      out_ch.seg_ones      <= erts_pkg::seg_of(ones);
    end
  end

  assign out_ch.valid = ov_r;

endmodule

/* hw/rtl/echo_range_to_segments_unit.sv */
// Echo pulse-width rangefinder. Each input beat is one prescaled timer tick carrying a
// start flag and the sampled echo level. start_req clears the 8-bit wrapping tick
// counter and arms the unit; the unit then captures the count at echo high and again
// at echo low, and the low capture yields one result beat. If fall is above rise the
// result is floor((fall - rise) * range_scale / 1000) cm with updated = 1, saturated at
// 2047; otherwise the previous range repeats with updated = 0. Each result also carries
// the four decimal digits as segment codes, bits g..a. Rate: one input beat per cycle
// while in_ch.ready is high. The back pipeline runs multiply, reciprocal multiply,
// correct and saturate, then four digit stages and the output register. A four-entry
// job queue sits between the tick front and the back pipeline, so in_ch.ready drops
// only once four results are waiting behind a stalled output. range_scale (reset
// 1098) is written through cfg_we/cfg_wdata; the user must write it only while the
// unit is idle, which the block itself does not enforce. No clearing pass follows
// reset.
module echo_range_to_segments_unit (
  input  logic                            clk,
  input  logic                            rst_n,
  erts_in_if.sink                         in_ch,
  erts_out_if.source                      out_ch,
  input  logic                            cfg_we,
  input  logic [erts_pkg::SCALE_BITS-1:0] cfg_wdata
);

  logic [erts_pkg::SCALE_BITS-1:0] scale_r;

  logic           push;
  erts_pkg::job_t push_job;
  logic           pop;
  erts_pkg::job_t head;
  logic           avail;
  logic           q_full;

  // Scale register; take a write on any edge with cfg_we high.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r <= erts_pkg::SCALE_RESET;
    end else if (cfg_we) begin
      scale_r <= cfg_wdata;
    end
  end

  // Front: count beats (start_req clears the counter), track phase, emit a job on echo low.
  erts_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .q_full (q_full),
    .push   (push),
    .job    (push_job)
  );

  // Queue: hold finished measurements until the back pipeline takes them.
  erts_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head     (head),
    .avail    (avail),
    .full     (q_full)
  );

  // Back: convert ticks to centimetres, split digits, drive the result beat.
  erts_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .range_scale (scale_r),
    .head        (head),
    .avail       (avail),
    .pop         (pop),
    .out_ch      (out_ch)
  );

endmodule

/* hw/rtl/erts_checker.sv */
// Port-level checker of the echo range unit and its bind to the top level.
// Depends on erts_pkg and echo_range_to_segments_unit_macros.svh.
`include "echo_range_to_segments_unit_macros.svh"

module erts_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic [erts_pkg::RANGE_BITS-1:0] range_cm,
  input logic                            updated,
  input logic [erts_pkg::SEG_BITS-1:0]   seg_thousands
);

  logic [erts_pkg::RANGE_BITS-1:0] last_r;
  logic                            fire;

  assign fire = out_valid && out_ready;

  // Track the last range delivered.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_r <= '0;
    end else if (fire) begin
      last_r <= range_cm;
    end
  end

  `ERTS_ASSERT_RST(a_no_out_after_reset, !rst_n, !out_valid, "result beat right after reset")
  `ERTS_ASSERT_NEXT(a_stall_holds, out_valid && !out_ready, out_valid && $stable(range_cm), "stalled result changed")
  `ERTS_ASSERT_IMPL(a_held_range, fire && !updated, range_cm == last_r, "held range differs from last result")
  `ERTS_ASSERT_IMPL(a_thousands_code, out_valid, seg_thousands == erts_pkg::seg_of(4'd0) || seg_thousands == erts_pkg::seg_of(4'd1) || seg_thousands == erts_pkg::seg_of(4'd2), "bad thousands code")

endmodule

bind echo_range_to_segments_unit erts_checker u_erts_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .range_cm      (out_ch.range_cm),
  .updated       (out_ch.updated),
  .seg_thousands (out_ch.seg_thousands)
);
